// ===== design/assert_macros.svh =====
// Assertion helpers used by the design file two_qubit_state_simulator.sv.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/tqss_pkg.sv =====
// ----------------------------------------------------------------------------
// tqss_pkg
// Types and constants of the two-qubit state simulator.
// ----------------------------------------------------------------------------
package tqss_pkg;

  // Amplitude format: signed, two integer bits
  localparam int AMP_WIDTH = 16;
  localparam int FRAC_BITS = AMP_WIDTH - 2;

  // 1/sqrt(2) rounded into the amplitude format
  localparam longint HCOEF_L =
    (64'd1518500250 + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
  localparam logic signed [AMP_WIDTH:0] H_COEF = (AMP_WIDTH+1)'(HCOEF_L);

  localparam logic signed [AMP_WIDTH-1:0] AMP_ONE = AMP_WIDTH'(longint'(1) << FRAC_BITS);
  localparam logic signed [AMP_WIDTH-1:0] AMP_MAX = {1'b0, {(AMP_WIDTH-1){1'b1}}};
  localparam logic signed [AMP_WIDTH-1:0] AMP_MIN = {1'b1, {(AMP_WIDTH-1){1'b0}}};

  // Probability widths: magnitudes are cut to at most 16 bits
  localparam int PM_W   = (AMP_WIDTH > 16) ? 16 : AMP_WIDTH;
  localparam int PM_SH  = AMP_WIDTH - PM_W;
  localparam int PR_W   = 2 * PM_W;
  localparam int SUM_W  = PR_W + 2;
  localparam int QUO_W  = 32;

  // Action codes
  localparam logic [2:0] ACT_H0   = 3'd0;
  localparam logic [2:0] ACT_H1   = 3'd1;
  localparam logic [2:0] ACT_X0   = 3'd2;
  localparam logic [2:0] ACT_X1   = 3'd3;
  localparam logic [2:0] ACT_CNOT = 3'd4;
  localparam logic [2:0] ACT_MEAS = 3'd5;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] random_word;
  } in_item_t;

  typedef struct packed {
    logic signed [AMP_WIDTH-1:0] amp_a;
    logic signed [AMP_WIDTH-1:0] amp_b;
    logic signed [AMP_WIDTH-1:0] amp_c;
    logic signed [AMP_WIDTH-1:0] amp_d;
    logic                        measured;
    logic [1:0]                  outcome;
    logic                        relay;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HAD,
    ST_PROB,
    ST_DSET,
    ST_DIV,
    ST_ACC,
    ST_FIN
  } state_e;

endpackage

// ===== design/two_qubit_state_simulator.sv =====
// ----------------------------------------------------------------------------
// two_qubit_state_simulator
// Four real amplitudes of two qubits; Hadamard, X, CNOT and measurement.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | in_item_i  (action, random_word)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (amplitudes, flags)
//
// Swaps are made as the result is stored; a Hadamard works one amplitude per cycle on one multiplier.
// A measurement finds four probabilities, then, unless they sum to zero,
// four serial divisions (each: setup, 32 restoring steps, accumulate).
// Reset sets amplitude 0 to 1.0, the others and the relay flag to 0.
// One item is worked at a time; the finished result sits in an output
// register and a stalled result holds the next one in its last cycle.
module two_qubit_state_simulator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tqss_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tqss_pkg::out_item_t  out_item_o
);
  import tqss_pkg::*;

  state_e state_q, state_d;

  logic signed [AMP_WIDTH-1:0] amp_q [4];
  logic signed [AMP_WIDTH-1:0] hnew_q [4];
  logic [PR_W-1:0]  prob_q [4];
  logic [SUM_W-1:0] sum_q;
  logic [2:0]       act_q;
  logic [31:0]      rnd_q;
  logic [1:0]       step_q;
  logic [4:0]       bit_q;
  logic [SUM_W:0]   rem_q;
  logic [31:0]      dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic [31:0]      thr_q;
  logic [1:0]       pick_q;
  logic             found_q;
  logic             relay_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic accept;
  logic out_free;
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Hadamard datapath: one new amplitude per step
  logic [1:0] hmask, lo_idx, hi_idx;
  logic signed [AMP_WIDTH:0]     hsum;
  logic signed [2*AMP_WIDTH+1:0] hprod;
  logic signed [2*AMP_WIDTH+1:0] hshift;
  logic signed [AMP_WIDTH-1:0]   hres;
  always_comb begin
    hmask  = (act_q == ACT_H0) ? 2'b10 : 2'b01;
    lo_idx = step_q & ~hmask;
    hi_idx = step_q | hmask;
    if ((step_q & hmask) != 2'b00) begin
      hsum = {amp_q[lo_idx][AMP_WIDTH-1], amp_q[lo_idx]}
           - {amp_q[hi_idx][AMP_WIDTH-1], amp_q[hi_idx]};
    end else begin
      hsum = {amp_q[lo_idx][AMP_WIDTH-1], amp_q[lo_idx]}
           + {amp_q[hi_idx][AMP_WIDTH-1], amp_q[hi_idx]};
    end
    hprod  = (2*AMP_WIDTH+2)'(hsum) * (2*AMP_WIDTH+2)'(H_COEF)
           + ((2*AMP_WIDTH+2)'(1) << (FRAC_BITS - 1));
    hshift = hprod >>> FRAC_BITS;
    if (hshift > (2*AMP_WIDTH+2)'(AMP_MAX)) begin
      hres = AMP_MAX;
    end else if (hshift < (2*AMP_WIDTH+2)'(AMP_MIN)) begin
      hres = AMP_MIN;
    end else begin
      hres = hshift[AMP_WIDTH-1:0];
    end
  end

  // Probability of the amplitude at the current step
  logic [AMP_WIDTH-1:0] mag;
  logic [PM_W-1:0]      pmag;
  logic [PR_W-1:0]      pcur;
  always_comb begin
    mag  = amp_q[step_q][AMP_WIDTH-1] ? AMP_WIDTH'(-amp_q[step_q]) : amp_q[step_q];
    pmag = PM_W'(mag >> PM_SH);
    pcur = PR_W'(pmag) * PR_W'(pmag);
  end

  // Division setup and one restoring step
  logic [63:0]    dividend;
  logic [SUM_W:0] trial;
  logic           qbit;
  logic [31:0]    thr_new;
  always_comb begin
    dividend = {32'(prob_q[step_q]), 32'd0} - 64'(prob_q[step_q]);
    trial    = {rem_q[SUM_W-1:0], dsh_q[31]};
    qbit     = trial >= (SUM_W+1)'(sum_q);
    thr_new  = thr_q + quo_q;
  end

  // Final state of the item: swaps and collapse
  logic signed [AMP_WIDTH-1:0] amp_fin [4];
  logic                        relay_fin;
  always_comb begin
    amp_fin   = amp_q;
    relay_fin = relay_q;
    unique case (act_q)
      ACT_X0: begin
        amp_fin[0] = amp_q[2]; amp_fin[2] = amp_q[0];
        amp_fin[1] = amp_q[3]; amp_fin[3] = amp_q[1];
      end
      ACT_X1: begin
        amp_fin[0] = amp_q[1]; amp_fin[1] = amp_q[0];
        amp_fin[2] = amp_q[3]; amp_fin[3] = amp_q[2];
      end
      ACT_CNOT: begin
        amp_fin[2] = amp_q[3]; amp_fin[3] = amp_q[2];
      end
      ACT_MEAS: begin
        for (int j = 0; j < 4; j++) begin
          amp_fin[j] = (pick_q == 2'(j)) ? AMP_ONE : '0;
        end
        relay_fin = pick_q[0];
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) begin
        if (in_item_i.action == ACT_H0 || in_item_i.action == ACT_H1) begin
          state_d = ST_HAD;
        end else if (in_item_i.action == ACT_MEAS) begin
          state_d = ST_PROB;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_HAD:  if (step_q == 2'd3) state_d = ST_FIN;
      ST_PROB: if (step_q == 2'd3) begin
        state_d = ((sum_q + SUM_W'(pcur)) == '0) ? ST_FIN : ST_DSET;
      end
      ST_DSET: state_d = ST_DIV;
      ST_DIV:  if (bit_q == 5'd31) state_d = ST_ACC;
      ST_ACC:  state_d = (step_q == 2'd3) ? ST_FIN : ST_DSET;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      bit_q       <= '0;
      found_q     <= 1'b0;
      pick_q      <= '0;
      relay_q     <= 1'b0;
      out_valid_q <= 1'b0;
      amp_q[0]    <= AMP_ONE;
      amp_q[1]    <= '0;
      amp_q[2]    <= '0;
      amp_q[3]    <= '0;
    end else begin
      state_q <= state_d;
      // Raise valid as a result is stored, drop it once taken
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          step_q  <= '0;
          found_q <= 1'b0;
          pick_q  <= '0;
        end
        ST_HAD: begin
          step_q <= step_q + 2'd1;
          if (step_q == 2'd3) begin
            amp_q[0] <= hnew_q[0];
            amp_q[1] <= hnew_q[1];
            amp_q[2] <= hnew_q[2];
            amp_q[3] <= hres;
          end
        end
        ST_PROB: step_q <= step_q + 2'd1;
        ST_DSET: bit_q <= '0;
        ST_DIV:  bit_q <= bit_q + 5'd1;
        ST_ACC: begin
          step_q <= step_q + 2'd1;
          if (!found_q && rnd_q <= thr_new) begin
            found_q <= 1'b1;
            pick_q  <= step_q;
          end
        end
        ST_FIN: if (out_free) begin
          amp_q   <= amp_fin;
          relay_q <= relay_fin;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (accept) begin
        act_q <= in_item_i.action;
        rnd_q <= in_item_i.random_word;
        sum_q <= '0;
        thr_q <= '0;
      end
      ST_HAD:  hnew_q[step_q] <= hres;
      ST_PROB: begin
        prob_q[step_q] <= pcur;
        sum_q          <= sum_q + SUM_W'(pcur);
      end
      ST_DSET: begin
        rem_q <= (SUM_W+1)'(dividend[63:32]);
        dsh_q <= dividend[31:0];
      end
      ST_DIV: begin
        rem_q <= qbit ? (trial - (SUM_W+1)'(sum_q)) : trial;
        dsh_q <= {dsh_q[30:0], 1'b0};
        quo_q <= {quo_q[QUO_W-2:0], qbit};
      end
      ST_ACC:  thr_q <= thr_new;
      ST_FIN: if (out_free) begin
        out_q.amp_a    <= amp_fin[0];
        out_q.amp_b    <= amp_fin[1];
        out_q.amp_c    <= amp_fin[2];
        out_q.amp_d    <= amp_fin[3];
        out_q.measured <= (act_q == ACT_MEAS);
        out_q.outcome  <= (act_q == ACT_MEAS) ? pick_q : 2'd0;
        out_q.relay    <= relay_fin;
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_relay_outcome, clk_i, rst_ni, out_valid_o && out_item_o.measured, out_item_o.relay == out_item_o.outcome[0])
  `ASSERT_IMPLY(a_outcome_zero, clk_i, rst_ni, out_valid_o && !out_item_o.measured, out_item_o.outcome == 2'd0)
  `ASSERT_IMPLY(a_div_rem, clk_i, rst_ni, state_q == ST_DIV, rem_q < (SUM_W+1)'(sum_q))
  `ASSERT_NEXT(a_fin_out, clk_i, rst_ni, state_q == ST_FIN && out_free, out_valid_o && state_q == ST_IDLE)

endmodule
